FILE: sv/rsu_pkg.sv
// Package for the relative exception table sorter.
// Holds sizes, the controller state type and the memory write request.
// No dependencies.
package rsu_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 64;
    localparam int DATA_W      = 32;
    localparam int SLOT_SHIFT  = 3;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] insn;
        logic [DATA_W-1:0] fixup;
    } t_mem_wr;

endpackage

FILE: sv/rsu_in_if.sv
// Input item channel of the sorter: one table entry per item.
// Depends on rsu_pkg.
interface rsu_in_if;
    logic                       valid;
    logic                       ready;
    logic [rsu_pkg::DATA_W-1:0] insn_offset;
    logic [rsu_pkg::DATA_W-1:0] fixup_offset;
    logic                       last_entry;

    modport source (output valid, insn_offset, fixup_offset, last_entry, input ready);
    modport sink   (input valid, insn_offset, fixup_offset, last_entry, output ready);
endinterface

FILE: sv/rsu_out_if.sv
// Result item channel of the sorter: one rebased entry per item.
// Depends on rsu_pkg.
interface rsu_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsu_pkg::DATA_W-1:0] sorted_insn;
    logic [rsu_pkg::DATA_W-1:0] sorted_fixup;
    logic                       final_out;
    logic                       overflowed;

    modport source (output valid, sorted_insn, sorted_fixup, final_out, overflowed,
                    input ready);
    modport sink   (input valid, sorted_insn, sorted_fixup, final_out, overflowed,
                    output ready);
endinterface

FILE: sv/rsu_cfg_if.sv
// Configuration write channel: carries the section base address.
// Depends on rsu_pkg.
interface rsu_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [rsu_pkg::KEY_W-1:0] section_base;

    modport source (output valid, section_base, input ready);
    modport sink   (input valid, section_base, output ready);
endinterface

FILE: sv/relative_extable_sorter_unit.sv
// Relative exception table sorter, top level.
// Loading takes one item per cycle; the last item starts a stable selection sort.
// Each result item is found by one scan of the stored entries in the key memory
// through its single read port.
// Synchronous active-low reset empties the table and clears section_base to zero.
// Depends on rsu_pkg, the channel interfaces, rsu_entry_mem and rsu_ctrl.
module relative_extable_sorter_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsu_cfg_if.sink   i_cfg,
    rsu_in_if.sink    i_in,
    rsu_out_if.source o_out
);

    logic [rsu_pkg::KEY_W-1:0]  r_section_base;
    rsu_pkg::t_mem_wr           wr;
    logic [rsu_pkg::IDX_W-1:0]  rd_addr;
    logic [rsu_pkg::KEY_W-1:0]  rd_key;
    logic [rsu_pkg::DATA_W-1:0] rd_insn;
    logic [rsu_pkg::DATA_W-1:0] rd_fixup;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_base <= '0;
        end else if (i_cfg.valid) begin
            r_section_base <= i_cfg.section_base;
        end
    end

    rsu_entry_mem u_mem (
        .i_clk      (i_clk),
        .i_wr       (wr),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_insn  (rd_insn),
        .o_rd_fixup (rd_fixup)
    );

    rsu_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_section_base (r_section_base),
        .i_in           (i_in),
        .o_out          (o_out),
        .o_wr           (wr),
        .o_rd_addr      (rd_addr),
        .i_rd_key       (rd_key),
        .i_rd_insn      (rd_insn),
        .i_rd_fixup     (rd_fixup)
    );

    a_no_load_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("item accepted while a result is pending");

    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_entry) |=> !i_in.ready)
        else $error("loading continued after last entry");

    a_final_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.final_out) |=> (i_in.ready && !o_out.valid))
        else $error("table not reopened after final result");

endmodule

FILE: sv/rsu_entry_mem.sv
// Entry memory: key and offset arrays, one write port, one registered read port.
// Depends on rsu_pkg.
module rsu_entry_mem (
    input  logic                       i_clk,
    input  rsu_pkg::t_mem_wr           i_wr,
    input  logic [rsu_pkg::IDX_W-1:0]  i_rd_addr,
    output logic [rsu_pkg::KEY_W-1:0]  o_rd_key,
    output logic [rsu_pkg::DATA_W-1:0] o_rd_insn,
    output logic [rsu_pkg::DATA_W-1:0] o_rd_fixup
);

    logic [rsu_pkg::KEY_W-1:0]  r_key_mem   [rsu_pkg::MAX_ENTRIES];
    logic [rsu_pkg::DATA_W-1:0] r_insn_mem  [rsu_pkg::MAX_ENTRIES];
    logic [rsu_pkg::DATA_W-1:0] r_fixup_mem [rsu_pkg::MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_key_mem[i_wr.addr]   <= i_wr.key;
            r_insn_mem[i_wr.addr]  <= i_wr.insn;
            r_fixup_mem[i_wr.addr] <= i_wr.fixup;
        end
        o_rd_key   <= r_key_mem[i_rd_addr];
        o_rd_insn  <= r_insn_mem[i_rd_addr];
        o_rd_fixup <= r_fixup_mem[i_rd_addr];
    end

endmodule

FILE: sv/rsu_ctrl.sv
// Sorter controller: loads entries, scans the key memory for the next
// smallest unemitted key, rebases and emits it. Depends on rsu_pkg,
// rsu_in_if and rsu_out_if.
module rsu_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [rsu_pkg::KEY_W-1:0]  i_section_base,
    rsu_in_if.sink                     i_in,
    rsu_out_if.source                  o_out,
    output rsu_pkg::t_mem_wr           o_wr,
    output logic [rsu_pkg::IDX_W-1:0]  o_rd_addr,
    input  logic [rsu_pkg::KEY_W-1:0]  i_rd_key,
    input  logic [rsu_pkg::DATA_W-1:0] i_rd_insn,
    input  logic [rsu_pkg::DATA_W-1:0] i_rd_fixup
);

    rsu_pkg::t_state                   r_state, n_state;
    logic [rsu_pkg::CNT_W-1:0]         r_count;
    logic                              r_ovf;
    logic [rsu_pkg::KEY_W-1:0]         r_prev_key;
    logic [rsu_pkg::IDX_W-1:0]         r_prev_idx;
    logic [rsu_pkg::CNT_W-1:0]         r_scan;
    logic                              r_chk;
    logic [rsu_pkg::IDX_W-1:0]         r_chk_idx;
    logic                              r_have;
    logic [rsu_pkg::KEY_W-1:0]         r_best_key;
    logic [rsu_pkg::IDX_W-1:0]         r_best_idx;
    logic [rsu_pkg::CNT_W-1:0]         r_dst;
    logic                              r_out_vld;
    logic [rsu_pkg::DATA_W-1:0]        r_out_insn;
    logic [rsu_pkg::DATA_W-1:0]        r_out_fixup;
    logic                              r_out_fin;
    logic                              r_out_ovf;

    logic                              in_acc;
    logic                              out_acc;
    logic                              has_room;
    logic                              issue;
    logic                              scan_done;
    logic                              after_prev;
    logic                              take;
    logic [rsu_pkg::DATA_W-1:0]        shift;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_acc   = r_out_vld && o_out.ready;
    assign has_room  = r_count < rsu_pkg::CNT_W'(rsu_pkg::MAX_ENTRIES);
    assign issue     = r_scan < r_count;
    assign scan_done = (r_state == rsu_pkg::ST_SCAN) && !issue && !r_chk;

    // candidate must follow the last emitted entry in (key, slot) order
    assign after_prev = (i_rd_key > r_prev_key)
                     || ((i_rd_key == r_prev_key) && (r_chk_idx > r_prev_idx));
    assign take       = r_chk && ((r_dst == '0) || after_prev)
                     && (!r_have || i_rd_key < r_best_key);

    // 8 * (origin - destination), wrapping at 32 bits
    assign shift = ({{(rsu_pkg::DATA_W-rsu_pkg::IDX_W){1'b0}}, r_best_idx}
                  - {{(rsu_pkg::DATA_W-rsu_pkg::IDX_W){1'b0}}, r_dst[rsu_pkg::IDX_W-1:0]})
                  << rsu_pkg::SLOT_SHIFT;

    assign i_in.ready = (r_state == rsu_pkg::ST_LOAD);

    assign o_wr.en    = in_acc && has_room;
    assign o_wr.addr  = r_count[rsu_pkg::IDX_W-1:0];
    assign o_wr.key   = i_section_base
                      + {{(rsu_pkg::KEY_W-rsu_pkg::IDX_W-rsu_pkg::SLOT_SHIFT){1'b0}},
                         r_count[rsu_pkg::IDX_W-1:0], {rsu_pkg::SLOT_SHIFT{1'b0}}}
                      + {{(rsu_pkg::KEY_W-rsu_pkg::DATA_W){i_in.insn_offset[rsu_pkg::DATA_W-1]}},
                         i_in.insn_offset};
    assign o_wr.insn  = i_in.insn_offset;
    assign o_wr.fixup = i_in.fixup_offset;

    assign o_rd_addr = scan_done ? r_best_idx : r_scan[rsu_pkg::IDX_W-1:0];

    assign o_out.valid        = r_out_vld;
    assign o_out.sorted_insn  = r_out_insn;
    assign o_out.sorted_fixup = r_out_fixup;
    assign o_out.final_out    = r_out_fin;
    assign o_out.overflowed   = r_out_ovf;

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsu_pkg::ST_LOAD: begin
                if (in_acc && i_in.last_entry) n_state = rsu_pkg::ST_SCAN;
            end
            rsu_pkg::ST_SCAN: begin
                if (scan_done) n_state = rsu_pkg::ST_FETCH;
            end
            rsu_pkg::ST_FETCH: begin
                n_state = rsu_pkg::ST_EMIT;
            end
            rsu_pkg::ST_EMIT: begin
                if (out_acc) n_state = r_out_fin ? rsu_pkg::ST_LOAD : rsu_pkg::ST_SCAN;
            end
            default: n_state = rsu_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rsu_pkg::ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_scan    <= '0;
            r_chk     <= 1'b0;
            r_have    <= 1'b0;
            r_dst     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chk   <= (r_state == rsu_pkg::ST_SCAN) && issue;
            if (in_acc) begin
                if (has_room) r_count <= r_count + rsu_pkg::CNT_W'(1);
                else          r_ovf   <= 1'b1;
                r_scan <= '0;
                r_have <= 1'b0;
                r_dst  <= '0;
            end
            if ((r_state == rsu_pkg::ST_SCAN) && issue) r_scan <= r_scan + rsu_pkg::CNT_W'(1);
            if (take) r_have <= 1'b1;
            if (r_state == rsu_pkg::ST_FETCH) begin
                r_out_vld <= 1'b1;
            end
            if (out_acc) begin
                r_out_vld <= 1'b0;
                r_dst     <= r_dst + rsu_pkg::CNT_W'(1);
                r_scan    <= '0;
                r_have    <= 1'b0;
                if (r_out_fin) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_scan[rsu_pkg::IDX_W-1:0];
        if (take) begin
            r_best_key <= i_rd_key;
            r_best_idx <= r_chk_idx;
        end
        if (r_state == rsu_pkg::ST_FETCH) begin
            r_prev_key  <= r_best_key;
            r_prev_idx  <= r_best_idx;
            r_out_insn  <= i_rd_insn + shift;
            r_out_fixup <= i_rd_fixup + shift;
            r_out_fin   <= (r_dst + rsu_pkg::CNT_W'(1)) == r_count;
            r_out_ovf   <= r_ovf;
        end
    end

endmodule
